### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion shorthands, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ktg_pkg.sv
// ----------------------------------------------------------------------------
// ktg_pkg
// Types, codes and defaults shared by the keystroke timing guard modules.
// ----------------------------------------------------------------------------
package ktg_pkg;

    localparam int GAP_W        = 32;
    localparam int TIME_W       = 64;
    localparam int CODE_W       = 8;
    localparam int HOST_W       = 9;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 1;

    localparam int HISTORY_DEPTH_DEF = 10;

    localparam logic [GAP_W-1:0] MEAN_LIMIT_RST = 32'd12410000;
    localparam logic [GAP_W-1:0] DEV_LIMIT_RST  = 32'd1000000;

    localparam logic [HOST_W-1:0] HOST_CODE_OFFSET = 9'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEV_LIMIT  = 1'd1;

    typedef enum logic [1:0] {
        KEY_RELEASE = 2'd0,
        KEY_PRESS   = 2'd1,
        KEY_REPEAT  = 2'd2
    } key_state_t;

    typedef enum logic [1:0] {
        ACT_NONE        = 2'd0,
        ACT_PRESS       = 2'd1,
        ACT_RELEASE     = 2'd2,
        ACT_RELEASE_ALL = 2'd3
    } action_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic [1:0]        key_state;
        logic [TIME_W-1:0] time_ns;
    } key_item_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [HOST_W-1:0] host_key_code;
        logic              blocked;
    } verdict_t;

    // Window engine report back to the sequencer
    typedef struct packed {
        logic done;
        logic hit;
    } win_status_t;

endpackage

### src/ktg_ram.sv
// ----------------------------------------------------------------------------
// ktg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ktg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/ktg_window.sv
// ----------------------------------------------------------------------------
// ktg_window
// Walk the newest gaps in memory and test mean and spread against the limits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ktg_window
    import ktg_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0] win_count,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] head,
    input  logic [GAP_W-1:0]                 mean_limit,
    input  logic [GAP_W-1:0]                 dev_limit,
    output logic                             rd_en,
    output logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    input  logic [GAP_W-1:0]                 rd_data,
    output win_status_t                      status
);

    localparam int CW     = $clog2(HISTORY_DEPTH + 1);
    localparam int PW     = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = GAP_W + CW;
    localparam int SQS_W  = 2 * GAP_W + CW;
    localparam int WIDE_W = 2 * GAP_W + 2 * CW;
    localparam int LO_W   = 2 * GAP_W;
    localparam int XW     = GAP_W + CW;

    typedef enum logic [2:0] {
        W_IDLE,
        W_READ,
        W_PRODUCT,
        W_COMBINE,
        W_JUDGE
    } win_state_t;

    win_state_t        state_reg, state_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     issued_reg, issued_next;
    logic [PW-1:0]     addr_reg, addr_next;
    logic              v1_reg, v1_next;
    logic              v2_reg, v2_next;
    logic [LO_W-1:0]   sq_reg, sq_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SQS_W-1:0]  sumsq_reg, sumsq_next;
    logic [SUM_W-1:0]  mean_prod_reg, mean_prod_next;
    logic [LO_W-1:0]   lim_sq_reg, lim_sq_next;
    logic [2*CW-1:0]   pair_reg, pair_next;
    logic [WIDE_W-1:0] nsumsq_reg, nsumsq_next;
    logic [LO_W-1:0]   lo_sq_reg, lo_sq_next;
    logic [XW-1:0]     cross_reg, cross_next;
    logic [2*CW-1:0]   hi_sq_reg, hi_sq_next;
    logic              mean_hit_reg, mean_hit_next;
    logic [WIDE_W-1:0] bound_reg, bound_next;
    logic [WIDE_W-1:0] sum_sq_reg, sum_sq_next;
    logic              done_reg, done_next;
    logic              hit_reg, hit_next;

    logic [GAP_W-1:0]  sum_lo;
    logic [CW-1:0]     sum_hi;
    logic [WIDE_W-1:0] spread;

    assign sum_lo  = sum_reg[GAP_W-1:0];
    assign sum_hi  = sum_reg[SUM_W-1:GAP_W];
    assign spread  = nsumsq_reg - sum_sq_reg;
    assign rd_en   = (state_reg == W_READ) && (issued_reg != n_reg);
    assign rd_addr = addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        issued_next    = issued_reg;
        addr_next      = addr_reg;
        v1_next        = 1'b0;
        v2_next        = 1'b0;
        sq_next        = sq_reg;
        sum_next       = sum_reg;
        sumsq_next     = sumsq_reg;
        mean_prod_next = mean_prod_reg;
        lim_sq_next    = lim_sq_reg;
        pair_next      = pair_reg;
        nsumsq_next    = nsumsq_reg;
        lo_sq_next     = lo_sq_reg;
        cross_next     = cross_reg;
        hi_sq_next     = hi_sq_reg;
        mean_hit_next  = mean_hit_reg;
        bound_next     = bound_reg;
        sum_sq_next    = sum_sq_reg;
        done_next      = 1'b0;
        hit_next       = hit_reg;

        case (state_reg)
            W_IDLE:
            begin
                if (start)
                begin
                    n_next      = win_count;
                    addr_next   = head;
                    issued_next = '0;
                    sum_next    = '0;
                    sumsq_next  = '0;
                    state_next  = W_READ;
                end
            end
            W_READ:
            begin
                // Newest first: step the read pointer backward around the ring
                if (rd_en)
                begin
                    issued_next = issued_reg + 1'b1;
                    addr_next   = (addr_reg == '0) ? PW'(HISTORY_DEPTH - 1)
                                                   : addr_reg - 1'b1;
                end
                v1_next = rd_en;
                v2_next = v1_reg;
                if (v1_reg)
                begin
                    sq_next  = LO_W'(rd_data) * LO_W'(rd_data);
                    sum_next = sum_reg + SUM_W'(rd_data);
                end
                if (v2_reg)
                begin
                    sumsq_next = sumsq_reg + SQS_W'(sq_reg);
                end
                if ((issued_reg == n_reg) && !v1_reg && !v2_reg)
                begin
                    state_next = W_PRODUCT;
                end
            end
            W_PRODUCT:
            begin
                mean_prod_next = SUM_W'(mean_limit) * SUM_W'(n_reg);
                lim_sq_next    = LO_W'(dev_limit) * LO_W'(dev_limit);
                pair_next      = (2*CW)'(n_reg) * (2*CW)'(n_reg - 1'b1);
                nsumsq_next    = WIDE_W'(sumsq_reg) * WIDE_W'(n_reg);
                lo_sq_next     = LO_W'(sum_lo) * LO_W'(sum_lo);
                cross_next     = XW'(sum_lo) * XW'(sum_hi);
                hi_sq_next     = (2*CW)'(sum_hi) * (2*CW)'(sum_hi);
                state_next     = W_COMBINE;
            end
            W_COMBINE:
            begin
                mean_hit_next = sum_reg < mean_prod_reg;
                bound_next    = WIDE_W'(lim_sq_reg) * WIDE_W'(pair_reg);
                sum_sq_next   = WIDE_W'(lo_sq_reg)
                              + (WIDE_W'(cross_reg) << (GAP_W + 1))
                              + (WIDE_W'(hi_sq_reg) << (2 * GAP_W));
                state_next    = W_JUDGE;
            end
            W_JUDGE:
            begin
                // n*sumsq - sum^2 against L^2*n*(n-1); zero limit never hits
                hit_next   = mean_hit_reg || ((n_reg >= CW'(2)) && (spread < bound_reg));
                done_next  = 1'b1;
                state_next = W_IDLE;
            end
            default:
            begin
                state_next = W_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= W_IDLE;
            issued_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        addr_reg      <= addr_next;
        sq_reg        <= sq_next;
        sum_reg       <= sum_next;
        sumsq_reg     <= sumsq_next;
        mean_prod_reg <= mean_prod_next;
        lim_sq_reg    <= lim_sq_next;
        pair_reg      <= pair_next;
        nsumsq_reg    <= nsumsq_next;
        lo_sq_reg     <= lo_sq_next;
        cross_reg     <= cross_next;
        hi_sq_reg     <= hi_sq_next;
        mean_hit_reg  <= mean_hit_next;
        bound_reg     <= bound_next;
        sum_sq_reg    <= sum_sq_next;
        hit_reg       <= hit_next;
    end

    assign status.done = done_reg;
    assign status.hit  = hit_reg;

    `ASSERT_IMPLY(a_reads_bounded, state_reg == W_READ, issued_reg <= n_reg, "read count past window")
    `ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "done held longer than one cycle")
    `ASSERT_IMPLY(a_start_idle, start, state_reg == W_IDLE, "window started while busy")

endmodule

### src/keystroke_timing_guard.sv
// ----------------------------------------------------------------------------
// keystroke_timing_guard
// Judge from press-to-press timing whether key events come from a machine,
// and forward, swallow or answer them with release-all.
// ----------------------------------------------------------------------------
//  Channel   Signals                          Dir  Handshake
//  key       key_valid/key_ready/key_item     in   valid/ready, key_item_t
//  verdict   verdict_valid/verdict_ready/     out  valid/ready, verdict_t
//            verdict
//  config    cfg_we/cfg_index/cfg_data        in   write on cfg_we, no wait
//
//  A transaction that needs the window walks the newest n gaps, n being the
//  window size (up to HISTORY_DEPTH), through the single read port of the gap
//  memory before its verdict. Events with no stored gap, or after the latch
//  is set, skip the walk and go from S_UPDATE straight to S_DONE.
//  Reset: control state clears at once; the gap memory needs no clearing pass,
//  since only the newest written entries, up to the gap count, are ever read.
//  Stalls: a finished verdict waits in the output register while the next
//  transaction is taken; S_DONE holds only while that register is full and not taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module keystroke_timing_guard
    import ktg_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   key_valid,
    output logic                   key_ready,
    input  key_item_t              key_item,
    output logic                   verdict_valid,
    input  logic                   verdict_ready,
    output verdict_t               verdict,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int PW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_TEST,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    key_item_t         item_reg, item_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [CW-1:0]     gap_count_reg, gap_count_next;
    logic [TIME_W-1:0] last_time_reg, last_time_next;
    logic              seen_reg, seen_next;
    logic              block_latch_reg, block_latch_next;
    logic [GAP_W-1:0]  mean_limit_reg, mean_limit_next;
    logic [GAP_W-1:0]  dev_limit_reg, dev_limit_next;
    verdict_t          res_reg, res_next;
    verdict_t          out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              is_press;
    logic              gap_write;
    logic [PW-1:0]     head_inc;
    logic [TIME_W-1:0] time_diff;
    logic [GAP_W-1:0]  gap_value;
    logic [CW-1:0]     count_upd;
    logic [CW-1:0]     win_count;
    logic              win_start;
    logic              mem_re;
    logic [PW-1:0]     mem_raddr;
    logic [GAP_W-1:0]  mem_rdata;
    logic [HOST_W-1:0] host_code;
    logic              out_free;
    win_status_t       win_status;

    assign key_ready     = (state_reg == S_IDLE);
    assign verdict_valid = out_valid_reg;
    assign verdict       = out_reg;
    assign out_free      = !out_valid_reg || verdict_ready;

    // Gap since the previous press: zero if time went backward, saturate at 32 bits
    assign is_press  = (item_reg.key_state == KEY_PRESS);
    assign time_diff = item_reg.time_ns - last_time_reg;
    assign gap_value = (item_reg.time_ns < last_time_reg)   ? '0 :
                       (time_diff[TIME_W-1:GAP_W] != '0)    ? '1 :
                                                              time_diff[GAP_W-1:0];
    assign gap_write = (state_reg == S_UPDATE) && is_press && seen_reg;
    assign head_inc  = (head_reg == PW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign count_upd = (gap_write && (gap_count_reg != CW'(HISTORY_DEPTH)))
                     ? gap_count_reg + 1'b1 : gap_count_reg;
    // Non-press events see one gap fewer than a press does once the ring is full
    assign win_count = (!is_press && (count_upd == CW'(HISTORY_DEPTH)))
                     ? CW'(HISTORY_DEPTH - 1) : count_upd;
    assign win_start = (state_reg == S_UPDATE) && (count_upd != '0) && !block_latch_reg;
    assign host_code = HOST_W'(item_reg.key_code) + HOST_CODE_OFFSET;

    ktg_ram #(
        .WIDTH (GAP_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_gap_ram (
        .clk   (clk),
        .we    (gap_write),
        .waddr (head_inc),
        .wdata (gap_value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ktg_window #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (win_start),
        .win_count  (win_count),
        .head       (gap_write ? head_inc : head_reg),
        .mean_limit (mean_limit_reg),
        .dev_limit  (dev_limit_reg),
        .rd_en      (mem_re),
        .rd_addr    (mem_raddr),
        .rd_data    (mem_rdata),
        .status     (win_status)
    );

    always_comb
    begin
        state_next       = state_reg;
        item_next        = item_reg;
        head_next        = head_reg;
        gap_count_next   = gap_count_reg;
        last_time_next   = last_time_reg;
        seen_next        = seen_reg;
        block_latch_next = block_latch_reg;
        mean_limit_next  = mean_limit_reg;
        dev_limit_next   = dev_limit_reg;
        res_next         = res_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        // Drop the verdict once it is taken
        if (out_valid_reg && verdict_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MEAN_LIMIT: mean_limit_next = cfg_data;
                CFG_DEV_LIMIT:  dev_limit_next  = cfg_data;
                default:        mean_limit_next = mean_limit_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (key_valid)
                begin
                    item_next  = key_item;
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                // Advance the ring on a press after the first
                if (gap_write)
                begin
                    head_next = head_inc;
                end
                gap_count_next = count_upd;
                if (is_press)
                begin
                    seen_next      = 1'b1;
                    last_time_next = item_reg.time_ns;
                end
                res_next.action        = ACT_NONE;
                res_next.host_key_code = '0;
                res_next.blocked       = block_latch_reg;
                if (count_upd != '0 && block_latch_reg)
                begin
                    res_next.action = ACT_RELEASE_ALL;
                end
                state_next = win_start ? S_TEST : S_DONE;
            end
            S_TEST:
            begin
                if (win_status.done)
                begin
                    res_next.host_key_code = '0;
                    res_next.blocked       = win_status.hit;
                    if (win_status.hit)
                    begin
                        block_latch_next = 1'b1;
                        res_next.action  = ACT_RELEASE_ALL;
                    end
                    else if (is_press)
                    begin
                        res_next.action        = ACT_PRESS;
                        res_next.host_key_code = host_code;
                    end
                    else if (item_reg.key_state == KEY_RELEASE)
                    begin
                        res_next.action        = ACT_RELEASE;
                        res_next.host_key_code = host_code;
                    end
                    else
                    begin
                        res_next.action = ACT_NONE;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            gap_count_reg   <= '0;
            last_time_reg   <= '0;
            seen_reg        <= 1'b0;
            block_latch_reg <= 1'b0;
            mean_limit_reg  <= MEAN_LIMIT_RST;
            dev_limit_reg   <= DEV_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            gap_count_reg   <= gap_count_next;
            last_time_reg   <= last_time_next;
            seen_reg        <= seen_next;
            block_latch_reg <= block_latch_next;
            mean_limit_reg  <= mean_limit_next;
            dev_limit_reg   <= dev_limit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    `ASSERT_ALWAYS(a_count_max, gap_count_reg <= CW'(HISTORY_DEPTH), "gap count past depth")
    `ASSERT_NEXT(a_latch_sticky, block_latch_reg, block_latch_reg, "block latch cleared")
    `ASSERT_IMPLY(a_blocked_action, verdict_valid && verdict.blocked, verdict.action == ACT_RELEASE_ALL, "blocked verdict without release-all")
    `ASSERT_IMPLY(a_window_has_gap, win_start, win_count != '0, "window started with no gap")

endmodule

### dv/keystroke_timing_guard_tb.sv
// ----------------------------------------------------------------------------
// keystroke_timing_guard_tb
// Self-checking bench for the keystroke timing guard: drive key events over
// the valid/ready input, predict every verdict from a local copy of the gap
// window and latch, and compare each verdict field by field in order.
// ----------------------------------------------------------------------------
module keystroke_timing_guard_tb;
    import ktg_pkg::*;

    localparam int DEPTH = HISTORY_DEPTH_DEF;

    // Key state value with no enum member; the block treats it as a repeat
    localparam logic [1:0] KEY_STATE_SPARE = 2'd3;

    localparam logic [63:0] GAP_MAX  = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] GAP_OVER = 64'h0000_0001_0000_0000;

    // ------------------------------------------------------------------------
    // Verdict scoreboard: mirror of the guard state plus the queue of verdicts
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class verdict_scoreboard;
        logic [31:0] mean_limit;
        logic [31:0] dev_limit;
        logic [31:0] gaps [DEPTH];
        int unsigned gap_count;
        logic [63:0] last_press;
        bit          seen_press;
        bit          latched;
        verdict_t    expected_verdicts [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned action_seen [4];

        function void reset_state();
            mean_limit = MEAN_LIMIT_RST;
            dev_limit  = DEV_LIMIT_RST;
            gap_count  = 0;
            last_press = '0;
            seen_press = 1'b0;
            latched    = 1'b0;
        endfunction

        function void write_limit(logic [CFG_INDEX_W-1:0] idx, logic [31:0] data);
            if (idx == CFG_MEAN_LIMIT)
                mean_limit = data;
            else if (idx == CFG_DEV_LIMIT)
                dev_limit = data;
        endfunction

        // Mean test first, then the spread test as a sum of squared pairwise
        // differences, which equals n*sumsq - sum^2 without forming that difference.
        function bit window_trips(int unsigned n);
            logic [63:0]  sum;
            logic [63:0]  d;
            logic [127:0] spread;
            logic [127:0] bound;
            int unsigned  i;
            int unsigned  j;
            sum = '0;
            for (i = 0; i < n; i++)
                sum += 64'(gaps[i]);
            if (sum < 64'(mean_limit) * 64'(n))
                return 1'b1;
            if (n < 2)
                return 1'b0;
            spread = '0;
            for (i = 0; i < n; i++)
            begin
                for (j = i + 1; j < n; j++)
                begin
                    d = (gaps[i] > gaps[j]) ? 64'(gaps[i] - gaps[j])
                                            : 64'(gaps[j] - gaps[i]);
                    spread += 128'(d * d);
                end
            end
            bound = 128'(dev_limit) * 128'(dev_limit) * 128'(n * (n - 1));
            return spread < bound;
        endfunction

        function void note_key(key_item_t k);
            verdict_t    v;
            logic [63:0] g;
            int unsigned n;
            int unsigned i;
            if (k.key_state == KEY_PRESS)
            begin
                if (seen_press)
                begin
                    g = (k.time_ns >= last_press) ? k.time_ns - last_press : 64'd0;
                    if (g > GAP_MAX)
                        g = GAP_MAX;
                    for (i = DEPTH - 1; i > 0; i--)
                        gaps[i] = gaps[i - 1];
                    gaps[0] = g[31:0];
                    if (gap_count < DEPTH)
                        gap_count++;
                end
                seen_press = 1'b1;
                last_press = k.time_ns;
            end
            v = '0;
            v.action = ACT_NONE;
            if (gap_count > 0)
            begin
                n = gap_count;
                if (k.key_state != KEY_PRESS && n > DEPTH - 1)
                    n = DEPTH - 1;
                if (!latched && window_trips(n))
                    latched = 1'b1;
                if (latched)
                    v.action = ACT_RELEASE_ALL;
                else if (k.key_state == KEY_PRESS)
                begin
                    v.action        = ACT_PRESS;
                    v.host_key_code = HOST_CODE_OFFSET + 9'(k.key_code);
                end
                else if (k.key_state == KEY_RELEASE)
                begin
                    v.action        = ACT_RELEASE;
                    v.host_key_code = HOST_CODE_OFFSET + 9'(k.key_code);
                end
            end
            v.blocked = latched;
            expected_verdicts = {expected_verdicts, v};
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10)
                $display("[%0t] verdict mismatch: %s", $time, what);
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (expected_verdicts.size() == 0)
            begin
                flag($sformatf("unexpected verdict action=%0d host=%0d blocked=%0d",
                               got.action, got.host_key_code, got.blocked));
                return;
            end
            want = expected_verdicts.pop_front();
            checked++;
            action_seen[want.action]++;
            if (got.action !== want.action || got.host_key_code !== want.host_key_code
                || got.blocked !== want.blocked)
                flag($sformatf("expected action=%0d host=%0d blocked=%0d, got %0d/%0d/%0d",
                               want.action, want.host_key_code, want.blocked,
                               got.action, got.host_key_code, got.blocked));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block signals. Every input has a known value at time 0.
    // ------------------------------------------------------------------------
    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   key_valid     = 1'b0;
    logic                   key_ready;
    key_item_t              key_item      = '0;
    logic                   verdict_valid;
    logic                   verdict_ready = 1'b0;
    verdict_t               verdict;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = CFG_MEAN_LIMIT;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    verdict_scoreboard verdicts;

    logic [63:0] now_ns     = '0;
    int unsigned keys_sent  = 0;
    int unsigned burst_left = 0;
    int unsigned settings   = 1;

    always #1 clk = ~clk;

    keystroke_timing_guard u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_ready     (key_ready),
        .key_item      (key_item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict       (verdict),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Verdict side: check every accepted verdict, and drive ready from a
    // rotating stall pattern that the stall counter reloads; a third of the
    // reloads give a stretch with no stalls at all. Keep at least two ready
    // bits per pattern so the output can never lock up.
    // ------------------------------------------------------------------------
    logic [15:0] stall_pat = 16'hFFFF;
    int unsigned stall_cnt = 0;

    always @(posedge clk)
    begin
        if (rst_n && verdict_valid && verdict_ready)
            verdicts.check_verdict(verdict);
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 48 == 0)
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                       : (16'($urandom) | 16'h0101);
        else
            stall_pat <= {stall_pat[14:0], stall_pat[15]};
        verdict_ready <= stall_pat[0];
    end

    // ------------------------------------------------------------------------
    // Key side drivers
    // ------------------------------------------------------------------------

    // Idle the sender between bursts. A burst runs back to back; after most
    // bursts valid drops for a while, so gaps land on every stage of the window walk.
    task automatic pace();
        int unsigned idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (idle > 0)
            begin
                key_valid <= 1'b0;
                repeat (idle) @(posedge clk);
            end
        end
        else
            burst_left--;
    endtask

    // Offer one key transaction and hold it until accepted. Valid stays high
    // afterwards unless pace() or drain() drops it, so back-to-back items
    // never lower and raise valid in the same step.
    task automatic send_key(input logic [7:0] code, input logic [1:0] kstate,
                            input logic [63:0] t);
        key_item_t item;
        item.key_code  = code;
        item.key_state = kstate;
        item.time_ns   = t;
        now_ns         = t;
        key_item  <= item;
        key_valid <= 1'b1;
        do
            @(posedge clk);
        while (!key_ready);
        verdicts.note_key(item);
        keys_sent++;
        pace();
    endtask

    // Drop valid and hold off until every owed verdict has come back.
    task automatic drain();
        key_valid <= 1'b0;
        do
            @(posedge clk);
        while (verdicts.expected_verdicts.size() != 0);
    endtask

    // Write both limits back to back; call only with the block drained.
    task automatic set_limits(input logic [31:0] mean, input logic [31:0] dev);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MEAN_LIMIT;
        cfg_data  <= mean;
        verdicts.write_limit(CFG_MEAN_LIMIT, mean);
        @(posedge clk);
        cfg_index <= CFG_DEV_LIMIT;
        cfg_data  <= dev;
        verdicts.write_limit(CFG_DEV_LIMIT, dev);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    // One keystroke: press after press_dt, optional autorepeats, release after hold.
    // The press-to-press gap is press_dt plus the previous hold and repeat offsets.
    task automatic stroke(input logic [63:0] press_dt, input logic [63:0] hold,
                          input int unsigned repeats);
        logic [7:0]  code;
        int unsigned k;
        code = 8'($urandom);
        send_key(code, KEY_PRESS, now_ns + press_dt);
        for (k = 0; k < repeats; k++)
            send_key(code, KEY_REPEAT, now_ns + 64'($urandom_range(1, 40_000_000)));
        send_key(code, KEY_RELEASE, now_ns + hold);
    endtask

    task automatic human_stroke();
        stroke(64'($urandom_range(20_000_000, 300_000_000)),
               64'($urandom_range(30_000_000, 120_000_000)),
               ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0);
    endtask

    // Fill the whole window with gaps past 32 bits so that a following
    // setting starts from a known, harmless window.
    task automatic saturate_gaps();
        repeat (DEPTH)
            stroke(GAP_OVER + 64'($urandom_range(0, 1_000_000)), 64'd20_000_000, 0);
    endtask

    task automatic noise_key();
        send_key(8'($urandom), 2'($urandom), {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------------
    // Run limit, far past the slowest legal run
    // ------------------------------------------------------------------------
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        verdicts = new();
        verdicts.reset_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset limits. Events before the second press are
        // swallowed; then forward presses and releases, swallow repeats and
        // the spare state, and walk time backwards, past 32 bits and to the
        // very top of the time range.
        send_key(8'd30, KEY_RELEASE, 64'd1000);
        send_key(8'd30, KEY_REPEAT, 64'd2000);
        send_key(8'd0, KEY_PRESS, 64'd5_000_000);
        send_key(8'd0, KEY_STATE_SPARE, 64'd6_000_000);
        send_key(8'd0, KEY_RELEASE, 64'd40_000_000);
        send_key(8'd255, KEY_PRESS, now_ns + 64'd150_000_000);
        send_key(8'd255, KEY_REPEAT, now_ns + 64'd30_000_000);
        send_key(8'd255, KEY_STATE_SPARE, now_ns + 64'd1);
        send_key(8'd255, KEY_RELEASE, now_ns + 64'd60_000_000);
        send_key(8'd0, KEY_PRESS, now_ns + 64'd110_000_000);
        send_key(8'd0, KEY_RELEASE, now_ns + 64'd45_000_000);
        // press earlier than the previous press stores a zero gap
        send_key(8'd128, KEY_PRESS, now_ns - 64'd300_000_000);
        send_key(8'd128, KEY_RELEASE, now_ns + 64'd70_000_000);
        // gap past 32 bits saturates; then a gap of exactly the 32-bit maximum
        send_key(8'd1, KEY_PRESS, now_ns + 64'h2_0000_0000);
        send_key(8'd1, KEY_PRESS, now_ns + GAP_MAX);
        send_key(8'd2, KEY_PRESS, '1);
        send_key(8'd2, KEY_RELEASE, '1);
        send_key(8'd3, KEY_PRESS, 64'd0);
        send_key(8'd3, KEY_RELEASE, 64'd90_000_000);
        send_key(8'd127, KEY_PRESS, now_ns + 64'd210_000_000);
        send_key(8'd127, KEY_RELEASE, now_ns + 64'd80_000_000);
        send_key(8'd64, KEY_PRESS, now_ns + 64'd160_000_000);
        send_key(8'd64, KEY_REPEAT, now_ns + 64'd20_000_000);
        send_key(8'd64, KEY_RELEASE, now_ns + 64'd40_000_000);
        drain();

        // Both limits zero: nothing can trip, so the bulk of the random part
        // exercises the gap store, window sizes and forwarding. Mix scales
        // from sub-microsecond to saturated, plus fully random noise.
        set_limits(32'd0, 32'd0);
        while (keys_sent < 440)
        begin
            case ($urandom_range(0, 11))
                0: noise_key();
                1: stroke(GAP_OVER + 64'($urandom), 64'($urandom_range(0, 1000)), 0);
                2: send_key(8'($urandom), KEY_STATE_SPARE,
                            now_ns + 64'($urandom_range(0, 5_000_000)));
                3: stroke(64'($urandom_range(0, 2000)), 64'($urandom_range(0, 2000)),
                          $urandom_range(0, 2));
                4: stroke(64'($urandom_range(1_000_000, 5_000_000)),
                          64'($urandom_range(0, 3_000_000)), 0);
                default: human_stroke();
            endcase
            if ($urandom_range(0, 79) == 0)
                drain();
        end
        saturate_gaps();
        drain();

        // Mean limit only, at 7 ms: human typing passes.
        set_limits(32'd7_000_000, 32'd0);
        while (keys_sent < 560)
        begin
            if ($urandom_range(0, 9) == 0)
                send_key(8'($urandom), KEY_STATE_SPARE,
                         now_ns + 64'($urandom_range(0, 10_000_000)));
            else
                human_stroke();
        end
        saturate_gaps();
        drain();

        // Highest mean limit with a fully saturated window: the sum equals
        // the limit times n, which must not trip, even for a gap of exactly
        // the 32-bit maximum.
        set_limits(32'hFFFF_FFFF, 32'd0);
        repeat (3)
            stroke(GAP_OVER + 64'($urandom_range(0, 1000)), 64'd5_000_000,
                   $urandom_range(0, 2));
        send_key(8'd9, KEY_PRESS, now_ns + GAP_OVER);
        send_key(8'd9, KEY_PRESS, now_ns + GAP_MAX);
        send_key(8'd9, KEY_STATE_SPARE, now_ns + 64'd1);
        send_key(8'd9, KEY_RELEASE, now_ns + 64'd1);
        drain();

        // Tight detector: human strokes with the odd run of machine-like
        // presses at about 2 ms with little jitter; a long enough run trips
        // the latch, and from then on every verdict is release-all.
        set_limits(32'd2_500_000, 32'd100_000);
        while (keys_sent < 750)
        begin
            if ($urandom_range(0, 11) == 0)
            begin
                repeat ($urandom_range(3, 12))
                    stroke(64'd1_000_000 + 64'($urandom_range(0, 60_000)),
                           64'd1_000_000, 0);
            end
            else if ($urandom_range(0, 15) == 0)
                send_key(8'($urandom), KEY_STATE_SPARE,
                         now_ns + 64'($urandom_range(0, 10_000_000)));
            else
                human_stroke();
            if ($urandom_range(0, 59) == 0)
                drain();
        end
        drain();

        // Highest limits on both registers.
        set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        while (keys_sent < 790)
        begin
            if ($urandom_range(0, 3) == 0)
                noise_key();
            else
                human_stroke();
        end
        drain();

        // Let any stray verdict surface before judging the run.
        repeat (40) @(posedge clk);

        $display("Ran %0d key events under %0d limit settings; verdicts checked: %0d",
                 keys_sent, settings, verdicts.checked);
        $display("  swallowed %0d, pressed %0d, released %0d, release-all %0d, mismatches %0d",
                 verdicts.action_seen[ACT_NONE], verdicts.action_seen[ACT_PRESS],
                 verdicts.action_seen[ACT_RELEASE], verdicts.action_seen[ACT_RELEASE_ALL],
                 verdicts.errors);
        if (verdicts.errors == 0 && verdicts.expected_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### files.f
+incdir+src
src/ktg_pkg.sv
src/ktg_ram.sv
src/ktg_window.sv
src/keystroke_timing_guard.sv
dv/keystroke_timing_guard_tb.sv
